// ===== rtl/core/lsvm_pkg.sv =====
`timescale 1ns / 1ps

package lsvm_pkg;

   localparam int unsigned CNT_W       = 5;
   localparam int unsigned MUL_STEPS   = 16;
   localparam int unsigned DECAY_STEPS = 32;

   localparam logic [1:0] FN_TRAIN   = 2'd0;
   localparam logic [1:0] FN_PREDICT = 2'd1;
   localparam logic [1:0] FN_LOAD    = 2'd2;

   localparam logic [2:0] CSR_STEP_SIZE      = 3'd0;
   localparam logic [2:0] CSR_REG_LAMBDA     = 3'd1;
   localparam logic [2:0] CSR_START_WEIGHT_X = 3'd2;
   localparam logic [2:0] CSR_START_WEIGHT_Y = 3'd3;
   localparam logic [2:0] CSR_START_BIAS     = 3'd4;

   localparam logic [15:0] STEP_SIZE_RESET  = 16'd328;
   localparam logic [15:0] REG_LAMBDA_RESET = 16'd328;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } ser_ctrl_type;

endpackage

// ===== rtl/core/lsvm_req_if.sv =====
`timescale 1ns / 1ps

interface lsvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [15:0] sample_x;
   logic signed [15:0] sample_y;
   logic               label_positive;

   modport source (output valid, func, sample_x, sample_y, label_positive, input ready);
   modport sink (input valid, func, sample_x, sample_y, label_positive, output ready);
endinterface

// ===== rtl/core/lsvm_rsp_if.sv =====
`timescale 1ns / 1ps

interface lsvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] score;
   logic               predicted_positive;
   logic               hinge_active;
   logic signed [31:0] weight_x_out;
   logic signed [31:0] weight_y_out;
   logic signed [31:0] bias_out;
   logic               saturated;

   modport source (output valid, score, predicted_positive, hinge_active, weight_x_out,
                   weight_y_out, bias_out, saturated, input ready);
   modport sink (input valid, score, predicted_positive, hinge_active, weight_x_out,
                 weight_y_out, bias_out, saturated, output ready);
endinterface

// ===== rtl/core/lsvm_dot_serial.sv =====
`timescale 1ns / 1ps

module lsvm_dot_serial (
   input  logic                  clock,
   input  lsvm_pkg::ser_ctrl_type ctrl,
   input  logic signed [31:0]    weight_x,
   input  logic signed [31:0]    weight_y,
   input  logic signed [15:0]    sample_x,
   input  logic signed [15:0]    sample_y,
   input  logic [15:0]           step_size,
   input  logic [15:0]           reg_lambda,
   output logic signed [50:0]    prod,
   output logic [31:0]           rate_lambda,
   output logic signed [32:0]    step_x,
   output logic signed [32:0]    step_y
);

   logic [15:0]        x_sr_ff, x_sr_in;
   logic [15:0]        y_sr_ff, y_sr_in;
   logic [15:0]        lam_sr_ff, lam_sr_in;
   logic [31:0]        lr_sh_ff, lr_sh_in;
   logic signed [34:0] hi_ff, hi_in;
   logic [15:0]        lo_ff, lo_in;
   logic [31:0]        k_ff, k_in;
   logic signed [32:0] gx_ff, gx_in;
   logic signed [32:0] gy_ff, gy_in;

   logic signed [34:0] wx_ext, wy_ext, tx, ty, hi_sum;
   logic signed [32:0] lr_ext, gtx, gty;

   always_comb begin
      wx_ext = {{3{weight_x[31]}}, weight_x};
      wy_ext = {{3{weight_y[31]}}, weight_y};
      lr_ext = {1'b0, lr_sh_ff};
      tx     = x_sr_ff[0] ? (ctrl.last ? -wx_ext : wx_ext) : '0;
      ty     = y_sr_ff[0] ? (ctrl.last ? -wy_ext : wy_ext) : '0;
      gtx    = x_sr_ff[0] ? (ctrl.last ? -lr_ext : lr_ext) : '0;
      gty    = y_sr_ff[0] ? (ctrl.last ? -lr_ext : lr_ext) : '0;
      hi_sum = hi_ff + tx + ty;

      x_sr_in   = x_sr_ff;
      y_sr_in   = y_sr_ff;
      lam_sr_in = lam_sr_ff;
      lr_sh_in  = lr_sh_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      k_in      = k_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      if (ctrl.load) begin
         x_sr_in   = sample_x;
         y_sr_in   = sample_y;
         lam_sr_in = reg_lambda;
         lr_sh_in  = {16'd0, step_size};
         hi_in     = '0;
         lo_in     = '0;
         k_in      = '0;
         gx_in     = '0;
         gy_in     = '0;
      end else if (ctrl.step) begin
         x_sr_in   = {1'b0, x_sr_ff[15:1]};
         y_sr_in   = {1'b0, y_sr_ff[15:1]};
         lam_sr_in = {1'b0, lam_sr_ff[15:1]};
         lr_sh_in  = {lr_sh_ff[30:0], 1'b0};
         hi_in     = {hi_sum[34], hi_sum[34:1]};
         lo_in     = {hi_sum[0], lo_ff[15:1]};
         k_in      = k_ff + (lam_sr_ff[0] ? lr_sh_ff : 32'd0);
         gx_in     = gx_ff + gtx;
         gy_in     = gy_ff + gty;
      end
   end

   always_ff @(posedge clock) begin
      x_sr_ff   <= x_sr_in;
      y_sr_ff   <= y_sr_in;
      lam_sr_ff <= lam_sr_in;
      lr_sh_ff  <= lr_sh_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      k_ff      <= k_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
   end

   assign prod        = {hi_ff, lo_ff};
   assign rate_lambda = k_ff;
   assign step_x      = gx_ff;
   assign step_y      = gy_ff;

endmodule

// ===== rtl/core/lsvm_decay_serial.sv =====
`timescale 1ns / 1ps

module lsvm_decay_serial (
   input  logic                  clock,
   input  lsvm_pkg::ser_ctrl_type ctrl,
   input  logic [31:0]           rate_lambda,
   input  logic signed [31:0]    weight_x,
   input  logic signed [31:0]    weight_y,
   output logic [33:0]           decay_x,
   output logic [33:0]           decay_y
);

   logic [31:0] mx_ff, mx_in;
   logic [31:0] my_ff, my_in;
   logic [31:0] k_sr_ff, k_sr_in;
   logic [32:0] hx_ff, hx_in;
   logic [31:0] lx_ff, lx_in;
   logic [32:0] hy_ff, hy_in;
   logic [31:0] ly_ff, ly_in;

   logic [32:0] sum_x, sum_y;

   always_comb begin
      sum_x = hx_ff + (k_sr_ff[0] ? {1'b0, mx_ff} : 33'd0);
      sum_y = hy_ff + (k_sr_ff[0] ? {1'b0, my_ff} : 33'd0);

      mx_in   = mx_ff;
      my_in   = my_ff;
      k_sr_in = k_sr_ff;
      hx_in   = hx_ff;
      lx_in   = lx_ff;
      hy_in   = hy_ff;
      ly_in   = ly_ff;
      if (ctrl.load) begin
         mx_in   = weight_x[31] ? $unsigned(-weight_x) : $unsigned(weight_x);
         my_in   = weight_y[31] ? $unsigned(-weight_y) : $unsigned(weight_y);
         k_sr_in = rate_lambda;
         hx_in   = '0;
         lx_in   = '0;
         hy_in   = '0;
         ly_in   = '0;
      end else if (ctrl.step) begin
         k_sr_in = {1'b0, k_sr_ff[31:1]};
         hx_in   = {1'b0, sum_x[32:1]};
         lx_in   = {sum_x[0], lx_ff[31:1]};
         hy_in   = {1'b0, sum_y[32:1]};
         ly_in   = {sum_y[0], ly_ff[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      k_sr_ff <= k_sr_in;
      hx_ff   <= hx_in;
      lx_ff   <= lx_in;
      hy_ff   <= hy_in;
      ly_ff   <= ly_in;
   end

   // round half up on the magnitude: bit 30 carries into the kept part
   assign decay_x = {1'b0, hx_ff[31:0], lx_ff[31]} + {33'd0, lx_ff[30]};
   assign decay_y = {1'b0, hy_ff[31:0], ly_ff[31]} + {33'd0, ly_ff[30]};

endmodule

// ===== rtl/core/linear_svm_sgd_step_unit.sv =====
`timescale 1ns / 1ps
// Flow: after its input transfer an item passes the 16-step bit-serial dot product, then
// the sum, abs, round and hinge states; a train item then runs the 32-step bit-serial
// weight decay and the update, and every item ends in the finish state, which waits until
// the response register is free. A new request is taken only when the unit is idle again.
// Reset: weights and bias clear to zero, registers take their reset values, no result pending.

module linear_svm_sgd_step_unit (
   input  logic        clock,
   input  logic        reset,
   lsvm_req_if.sink    req_chan,
   lsvm_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_SUM   = 4'd2;
   localparam logic [3:0] ST_ABS   = 4'd3;
   localparam logic [3:0] ST_RND   = 4'd4;
   localparam logic [3:0] ST_HINGE = 4'd5;
   localparam logic [3:0] ST_DECAY = 4'd6;
   localparam logic [3:0] ST_UPD   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   localparam logic [lsvm_pkg::CNT_W-1:0] MUL_LAST   = lsvm_pkg::CNT_W'(lsvm_pkg::MUL_STEPS - 1);
   localparam logic [lsvm_pkg::CNT_W-1:0] DECAY_LAST =
      lsvm_pkg::CNT_W'(lsvm_pkg::DECAY_STEPS - 1);
   localparam logic [lsvm_pkg::CNT_W-1:0] CNT_ONE    = lsvm_pkg::CNT_W'(1);

   localparam logic [35:0]        POS_LIMIT = 36'h07FFFFFFF;
   localparam logic [35:0]        NEG_LIMIT = 36'h080000000;
   localparam logic signed [34:0] SAT_MAX   = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN   = -35'sd2147483648;
   localparam logic signed [31:0] Q_ONE     = 32'sd65536;

   function automatic logic [32:0] clamp32(input logic signed [34:0] v);
      logic [32:0] r;
      if (v > SAT_MAX) begin
         r = {1'b1, 32'h7FFFFFFF};
      end else if (v < SAT_MIN) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic [15:0]        lr_ff, lam_ff;
   logic signed [31:0] swx_ff, swy_ff, sb_ff;
   logic signed [31:0] wx_ff, wx_in, wy_ff, wy_in, b_ff, b_in;
   logic [3:0]         state_ff, state_in;
   logic [lsvm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]         func_ff;
   logic               label_ff;
   logic signed [50:0] acc_ff;
   logic               neg_ff;
   logic [50:0]        mag_ff;
   logic signed [31:0] score_ff;
   logic               ssat_ff;
   logic               hinge_ff;
   logic               gxneg_ff, gyneg_ff;
   logic [32:0]        gxm_ff, gym_ff;
   logic signed [18:0] gx_ff, gy_ff;
   logic signed [34:0] nx_ff, ny_ff, nb_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_score_ff;
   logic               rsp_pred_ff, rsp_hinge_ff, rsp_sat_ff;
   logic signed [31:0] rsp_wx_ff, rsp_wy_ff, rsp_b_ff;
   logic               rsp_sat_in;

   lsvm_pkg::ser_ctrl_type dot_ctrl, dec_ctrl;
   logic signed [50:0] prod;
   logic [31:0]        rate_lambda;
   logic signed [32:0] step_x_acc, step_y_acc;
   logic [33:0]        decay_x, decay_y;

   logic               accept, fin_go, is_train;
   logic [35:0]        rnd_m;
   logic               rnd_sat;
   logic signed [31:0] rnd_score;
   logic [17:0]        gx_rnd, gy_rnd;
   logic signed [34:0] wx35, wy35, b35, dx35, dy35, gx35, gy35, lr35;
   logic signed [34:0] dec_x, dec_y, stx, sty, stb;
   logic [32:0]        cl_x, cl_y, cl_b;

   assign accept   = req_chan.valid && req_chan.ready;
   assign fin_go   = !rsp_valid_ff || rsp_chan.ready;
   assign is_train = (func_ff == lsvm_pkg::FN_TRAIN);

   always_comb begin
      dot_ctrl.load = accept;
      dot_ctrl.step = (state_ff == ST_MUL);
      dot_ctrl.last = (cnt_ff == MUL_LAST);
      dec_ctrl.load = (state_ff == ST_HINGE) && is_train;
      dec_ctrl.step = (state_ff == ST_DECAY);
      dec_ctrl.last = (cnt_ff == DECAY_LAST);
   end

   lsvm_dot_serial u_dot (
      .clock         (clock),
      .ctrl          (dot_ctrl),
      .weight_x      (wx_ff),
      .weight_y      (wy_ff),
      .sample_x      (req_chan.sample_x),
      .sample_y      (req_chan.sample_y),
      .step_size     (lr_ff),
      .reg_lambda    (lam_ff),
      .prod          (prod),
      .rate_lambda   (rate_lambda),
      .step_x        (step_x_acc),
      .step_y        (step_y_acc)
   );

   lsvm_decay_serial u_decay (
      .clock       (clock),
      .ctrl        (dec_ctrl),
      .rate_lambda (rate_lambda),
      .weight_x    (wx_ff),
      .weight_y    (wy_ff),
      .decay_x     (decay_x),
      .decay_y     (decay_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= lsvm_pkg::STEP_SIZE_RESET;
         lam_ff <= lsvm_pkg::REG_LAMBDA_RESET;
         swx_ff <= '0;
         swy_ff <= '0;
         sb_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            lsvm_pkg::CSR_STEP_SIZE:      lr_ff  <= csr_write_data[15:0];
            lsvm_pkg::CSR_REG_LAMBDA:     lam_ff <= csr_write_data[15:0];
            lsvm_pkg::CSR_START_WEIGHT_X: swx_ff <= csr_write_data;
            lsvm_pkg::CSR_START_WEIGHT_Y: swy_ff <= csr_write_data;
            lsvm_pkg::CSR_START_BIAS:     sb_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rnd_m     = mag_ff[50:15] + {35'd0, mag_ff[14]};
      rnd_sat   = neg_ff ? (rnd_m > NEG_LIMIT) : (rnd_m > POS_LIMIT);
      rnd_score = rnd_sat ? (neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF)
                          : (neg_ff ? -$signed(rnd_m[31:0]) : $signed(rnd_m[31:0]));
      gx_rnd    = gxm_ff[32:15] + {17'd0, gxm_ff[14]};
      gy_rnd    = gym_ff[32:15] + {17'd0, gym_ff[14]};

      wx35 = {{3{wx_ff[31]}}, wx_ff};
      wy35 = {{3{wy_ff[31]}}, wy_ff};
      b35  = {{3{b_ff[31]}}, b_ff};
      dx35 = {1'b0, decay_x};
      dy35 = {1'b0, decay_y};
      gx35 = {{16{gx_ff[18]}}, gx_ff};
      gy35 = {{16{gy_ff[18]}}, gy_ff};
      lr35 = {19'd0, lr_ff};
      dec_x = wx_ff[31] ? wx35 + dx35 : wx35 - dx35;
      dec_y = wy_ff[31] ? wy35 + dy35 : wy35 - dy35;
      stx   = hinge_ff ? (label_ff ? gx35 : -gx35) : '0;
      sty   = hinge_ff ? (label_ff ? gy35 : -gy35) : '0;
      stb   = hinge_ff ? (label_ff ? lr35 : -lr35) : '0;

      cl_x = clamp32(nx_ff);
      cl_y = clamp32(ny_ff);
      cl_b = clamp32(nb_ff);

      wx_in      = wx_ff;
      wy_in      = wy_ff;
      b_in       = b_ff;
      rsp_sat_in = ssat_ff;
      if (is_train) begin
         wx_in      = cl_x[31:0];
         wy_in      = cl_y[31:0];
         b_in       = cl_b[31:0];
         rsp_sat_in = ssat_ff | cl_x[32] | cl_y[32] | cl_b[32];
      end else if (func_ff == lsvm_pkg::FN_LOAD) begin
         wx_in = swx_ff;
         wy_in = swy_ff;
         b_in  = sb_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
               cnt_in   = '0;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + CNT_ONE;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:   state_in = ST_ABS;
         ST_ABS:   state_in = ST_RND;
         ST_RND:   state_in = ST_HINGE;
         ST_HINGE: begin
            cnt_in   = '0;
            state_in = is_train ? ST_DECAY : ST_FIN;
         end
         ST_DECAY: begin
            cnt_in = cnt_ff + CNT_ONE;
            if (dec_ctrl.last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD:   state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_FIN && fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wx_ff        <= '0;
         wy_ff        <= '0;
         b_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_FIN && fin_go) begin
            wx_ff <= wx_in;
            wy_ff <= wy_in;
            b_ff  <= b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_chan.func;
         label_ff <= req_chan.label_positive;
      end
      if (state_ff == ST_SUM) begin
         acc_ff   <= prod + {{4{b_ff[31]}}, b_ff, 15'd0};
         gxneg_ff <= step_x_acc[32];
         gyneg_ff <= step_y_acc[32];
         gxm_ff   <= step_x_acc[32] ? $unsigned(-step_x_acc) : $unsigned(step_x_acc);
         gym_ff   <= step_y_acc[32] ? $unsigned(-step_y_acc) : $unsigned(step_y_acc);
      end
      if (state_ff == ST_ABS) begin
         neg_ff <= acc_ff[50];
         mag_ff <= acc_ff[50] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
         gx_ff  <= gxneg_ff ? -$signed({1'b0, gx_rnd}) : $signed({1'b0, gx_rnd});
         gy_ff  <= gyneg_ff ? -$signed({1'b0, gy_rnd}) : $signed({1'b0, gy_rnd});
      end
      if (state_ff == ST_RND) begin
         score_ff <= rnd_score;
         ssat_ff  <= rnd_sat;
      end
      if (state_ff == ST_HINGE) begin
         hinge_ff <= label_ff ? (score_ff < Q_ONE) : (score_ff > -Q_ONE);
      end
      if (state_ff == ST_UPD) begin
         nx_ff <= dec_x + stx;
         ny_ff <= dec_y + sty;
         nb_ff <= b35 + stb;
      end
      if (state_ff == ST_FIN && fin_go) begin
         rsp_score_ff <= score_ff;
         rsp_pred_ff  <= !score_ff[31];
         rsp_hinge_ff <= hinge_ff;
         rsp_wx_ff    <= wx_in;
         rsp_wy_ff    <= wy_in;
         rsp_b_ff     <= b_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign req_chan.ready              = (state_ff == ST_IDLE);
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.score              = rsp_score_ff;
   assign rsp_chan.predicted_positive = rsp_pred_ff;
   assign rsp_chan.hinge_active       = rsp_hinge_ff;
   assign rsp_chan.weight_x_out       = rsp_wx_ff;
   assign rsp_chan.weight_y_out       = rsp_wy_ff;
   assign rsp_chan.bias_out           = rsp_b_ff;
   assign rsp_chan.saturated          = rsp_sat_ff;

   a_decay_only_train: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECAY) |-> is_train)
      else $error("decay pass on a non-train item");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff <= MUL_LAST))
      else $error("dot product step count overrun");

   a_predict_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && fin_go && func_ff != lsvm_pkg::FN_TRAIN
       && func_ff != lsvm_pkg::FN_LOAD) |=> (wx_ff == $past(wx_ff) && b_ff == $past(b_ff)))
      else $error("predict item changed the weights");

   a_sign_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && fin_go) |=> (rsp_chan.predicted_positive == !rsp_chan.score[31]))
      else $error("predicted class disagrees with score sign");

endmodule
